FILE: sv/bpks_pkg.sv
// Shared types, constants and hash function of the bounded probe key set.
package bpks_pkg;

  localparam int unsigned OpBits        = 2;
  localparam int unsigned KeyWidth      = 32;
  localparam int unsigned DefTableSlots = 1024;
  localparam int unsigned DefProbeCount = 4;
  localparam int unsigned DefKeyBits    = 32;
  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned QueuePtrBits  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntBits  = $clog2(QueueDepth + 1);
  localparam int unsigned HashShiftA    = 6;
  localparam int unsigned HashShiftB    = 3;

  typedef enum logic [OpBits-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  // Classified command as queued between the front and the back.
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_MISS   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [KeyWidth-1:0] key;
  } cmd_t;

  typedef struct packed {
    logic                    head_valid;
    logic [QueueCntBits-1:0] count;
  } queue_stat_t;

  typedef struct packed {
    logic sweeping;
    logic pop;
  } back_stat_t;

  function automatic logic [KeyWidth-1:0] hash_of(logic [KeyWidth-1:0] k);
    return (k >> HashShiftA) ^ (k >> HashShiftB);
  endfunction

endpackage

FILE: sv/bpks_in_if.sv
// Request channel: valid/ready handshake carrying op and key.
interface bpks_in_if;
  logic                          valid;
  logic                          ready;
  logic [bpks_pkg::OpBits-1:0]   op;
  logic [bpks_pkg::KeyWidth-1:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);
endinterface

FILE: sv/bpks_out_if.sv
// Result channel: valid/ready handshake carrying the lookup hit flag.
interface bpks_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, output hit, input ready);
  modport sink   (input valid, input hit, output ready);
endinterface

FILE: sv/bpks_front.sv
// Front end: accept requests, classify them and queue commands for the back end.
module bpks_front #(
  parameter int unsigned KEY_BITS = bpks_pkg::DefKeyBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bpks_in_if.sink               in_i,
  input  logic                  insert_enable_i,
  output bpks_pkg::cmd_t        head_o,
  input  logic                  pop_i,
  output bpks_pkg::queue_stat_t stat_o
);

  localparam logic [bpks_pkg::KeyWidth-1:0] KeyMask =
    (KEY_BITS >= bpks_pkg::KeyWidth) ? {bpks_pkg::KeyWidth{1'b1}} :
    ((bpks_pkg::KeyWidth'(1) << KEY_BITS) - bpks_pkg::KeyWidth'(1));

  bpks_pkg::cmd_t                        q_mem_q [bpks_pkg::QueueDepth];
  logic [bpks_pkg::QueuePtrBits-1:0]     wr_ptr_q, wr_ptr_d;
  logic [bpks_pkg::QueuePtrBits-1:0]     rd_ptr_q, rd_ptr_d;
  logic [bpks_pkg::QueueCntBits-1:0]     count_q, count_d;
  logic [bpks_pkg::KeyWidth-1:0]         key_m;
  bpks_pkg::cmd_t                        push_cmd;
  logic                                  keep;
  logic                                  accept;
  logic                                  push;

  assign in_i.ready = (count_q != bpks_pkg::QueueCntBits'(bpks_pkg::QueueDepth));
  assign accept     = in_i.valid && in_i.ready;
  assign key_m      = in_i.key & KeyMask;

  // Drop requests that leave no trace: disabled or zero-key inserts, unused op.
  always_comb begin
    keep         = 1'b0;
    push_cmd.key = key_m;
    push_cmd.cmd = bpks_pkg::CMD_LOOKUP;
    case (bpks_pkg::op_e'(in_i.op))
      bpks_pkg::OP_INSERT: begin
        keep         = insert_enable_i && (key_m != '0);
        push_cmd.cmd = bpks_pkg::CMD_INSERT;
      end
      bpks_pkg::OP_LOOKUP: begin
        keep         = 1'b1;
        push_cmd.cmd = (key_m == '0) ? bpks_pkg::CMD_MISS : bpks_pkg::CMD_LOOKUP;
      end
      bpks_pkg::OP_CLEAR: begin
        keep         = 1'b1;
        push_cmd.cmd = bpks_pkg::CMD_CLEAR;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = accept && keep;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == bpks_pkg::QueuePtrBits'(bpks_pkg::QueueDepth - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == bpks_pkg::QueuePtrBits'(bpks_pkg::QueueDepth - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= push_cmd;
    end
  end

  assign head_o            = q_mem_q[rd_ptr_q];
  assign stat_o.head_valid = (count_q != '0);
  assign stat_o.count      = count_q;

endmodule

FILE: sv/bpks_back.sv
// Back end: slot table memory, probe sequencer, clearing sweep and result register.
module bpks_back #(
  parameter int unsigned TABLE_SLOTS = bpks_pkg::DefTableSlots,
  parameter int unsigned PROBE_COUNT = bpks_pkg::DefProbeCount,
  parameter int unsigned KEY_BITS    = bpks_pkg::DefKeyBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bpks_pkg::cmd_t       head_i,
  input  logic                 head_valid_i,
  output logic                 pop_o,
  output bpks_pkg::back_stat_t stat_o,
  bpks_out_if.source           out_o
);

  localparam int unsigned IdxBits   = $clog2(TABLE_SLOTS);
  localparam int unsigned StoreBits = (KEY_BITS < bpks_pkg::KeyWidth) ? KEY_BITS :
                                      bpks_pkg::KeyWidth;
  localparam int unsigned ProbeBits = (PROBE_COUNT > 1) ? $clog2(PROBE_COUNT) : 1;

  typedef enum logic [3:0] {
    S_SWEEP = 4'b0001,
    S_IDLE  = 4'b0010,
    S_CHECK = 4'b0100,
    S_REPLY = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  logic                    is_lookup_q, is_lookup_d;
  logic [StoreBits-1:0]    key_q, key_d;
  logic [IdxBits-1:0]      home_q, home_d;
  logic [IdxBits-1:0]      slot_q, slot_d;
  logic [ProbeBits-1:0]    idx_q, idx_d;
  logic [IdxBits-1:0]      sweep_q, sweep_d;
  logic                    any_q, any_d;
  logic                    pend_q, pend_d;
  logic                    out_valid_q, out_valid_d;
  logic                    out_hit_q, out_hit_d;

  // Table entry: valid flag on top of the stored key.
  logic [StoreBits:0]      mem [TABLE_SLOTS];
  logic [StoreBits:0]      rd_q;
  logic                    mem_we;
  logic [IdxBits-1:0]      mem_wa;
  logic [StoreBits:0]      mem_wd;
  logic [IdxBits-1:0]      mem_ra;

  logic [bpks_pkg::KeyWidth-1:0] head_hash;
  logic                    slot_used;
  logic                    slot_match;
  logic                    last_probe;
  logic                    out_free;

  assign head_hash  = bpks_pkg::hash_of(head_i.key);
  assign slot_used  = rd_q[StoreBits];
  assign slot_match = slot_used && (rd_q[StoreBits-1:0] == key_q);
  assign last_probe = (idx_q == ProbeBits'(PROBE_COUNT - 1));
  assign out_free   = !out_valid_q || out_o.ready;

  always_comb begin
    state_d     = state_q;
    is_lookup_d = is_lookup_q;
    key_d       = key_q;
    home_d      = home_q;
    slot_d      = slot_q;
    idx_d       = idx_q;
    sweep_d     = sweep_q;
    any_d       = any_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    out_hit_d   = out_hit_q;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = sweep_q;
    mem_wd      = '0;
    mem_ra      = slot_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_SWEEP: begin
        mem_we  = 1'b1;
        mem_wa  = sweep_q;
        mem_wd  = '0;
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == {IdxBits{1'b1}}) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head_valid_i) begin
          pop_o       = 1'b1;
          key_d       = head_i.key[StoreBits-1:0];
          home_d      = head_hash[IdxBits-1:0];
          slot_d      = head_hash[IdxBits-1:0];
          idx_d       = '0;
          mem_ra      = head_hash[IdxBits-1:0];
          case (head_i.cmd)
            bpks_pkg::CMD_INSERT: begin
              is_lookup_d = 1'b0;
              state_d     = S_CHECK;
            end
            bpks_pkg::CMD_LOOKUP: begin
              is_lookup_d = 1'b1;
              pend_d      = 1'b0;
              // An empty set answers miss without probing.
              state_d     = any_q ? S_CHECK : S_REPLY;
            end
            bpks_pkg::CMD_MISS: begin
              pend_d  = 1'b0;
              state_d = S_REPLY;
            end
            bpks_pkg::CMD_CLEAR: begin
              any_d   = 1'b0;
              sweep_d = '0;
              state_d = S_SWEEP;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_CHECK: begin
        // Prefetch the next probe; a finished walk simply ignores it.
        mem_ra = slot_q + 1'b1;
        slot_d = slot_q + 1'b1;
        idx_d  = idx_q + 1'b1;
        if (is_lookup_q) begin
          if (!slot_used) begin
            pend_d  = 1'b0;
            state_d = S_REPLY;
          end else if (slot_match) begin
            pend_d  = 1'b1;
            state_d = S_REPLY;
          end else if (last_probe) begin
            pend_d  = 1'b0;
            state_d = S_REPLY;
          end
        end else begin
          if (slot_match) begin
            state_d = S_IDLE;
          end else if (!slot_used) begin
            mem_we  = 1'b1;
            mem_wa  = slot_q;
            mem_wd  = {1'b1, key_q};
            any_d   = 1'b1;
            state_d = S_IDLE;
          end else if (last_probe) begin
            mem_we  = 1'b1;
            mem_wa  = home_q;
            mem_wd  = {1'b1, key_q};
            any_d   = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_REPLY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_hit_d   = pend_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_SWEEP;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      sweep_q     <= '0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      any_q       <= any_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_lookup_q <= is_lookup_d;
    key_q       <= key_d;
    home_q      <= home_d;
    slot_q      <= slot_d;
    idx_q       <= idx_d;
    pend_q      <= pend_d;
    out_hit_q   <= out_hit_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[mem_ra];
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.hit       = out_hit_q;
  assign stat_o.sweeping = (state_q == S_SWEEP);
  assign stat_o.pop      = pop_o;

endmodule

FILE: sv/bounded_probe_key_set_unit.sv
// Top level of the bounded probe key set: front end, command queue and back end.
//
// A key membership set held in a TABLE_SLOTS-entry table with one read port and
// one write port and bounded linear probing: the home slot is
// ((key >> 6) ^ (key >> 3)) masked to the table size, and up to PROBE_COUNT
// consecutive slots are visited. Insert
// (op 0) stops on a stored match, fills the first empty slot, or overwrites the
// home slot when all probes are taken; it is dropped while insert_enable is 0
// or for a zero key. Lookup (op 1) returns one hit transaction; clear (op 2)
// empties the set; op 3 is dropped. Rate: the table memory gives one slot read
// per cycle, so an insert occupies the back end for its pop in S_IDLE and one
// S_CHECK step per slot visited (1 to PROBE_COUNT); a lookup adds an S_REPLY
// step, and a lookup of a zero key or on an empty set goes from S_IDLE straight
// to S_REPLY. A clear, and reset, start a clearing pass that writes one slot per
// cycle over all TABLE_SLOTS slots (1024 by default); requests queue behind it.
// A two-entry command queue lets the front accept requests while the back works,
// and a result register lets the back go on while a result waits to be taken.
module bounded_probe_key_set_unit #(
  parameter int unsigned TABLE_SLOTS = bpks_pkg::DefTableSlots,
  parameter int unsigned PROBE_COUNT = bpks_pkg::DefProbeCount,
  parameter int unsigned KEY_BITS    = bpks_pkg::DefKeyBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bpks_in_if.sink    in_i,
  bpks_out_if.source out_o,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i
);

  logic                  insert_enable_q;
  bpks_pkg::cmd_t        head;
  bpks_pkg::queue_stat_t q_stat;
  bpks_pkg::back_stat_t  b_stat;
  logic                  pop;

  // Held between writes; user must write it only while block is idle; unchecked.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      insert_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      insert_enable_q <= cfg_wdata_i;
    end
  end

  // Front: accept and classify each transaction, queue what the back must do.
  bpks_front #(
    .KEY_BITS (KEY_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_i            (in_i),
    .insert_enable_i (insert_enable_q),
    .head_o          (head),
    .pop_i           (pop),
    .stat_o          (q_stat)
  );

  // Back: walk the probes, update the table, sweep on clear, deliver results.
  bpks_back #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .PROBE_COUNT (PROBE_COUNT),
    .KEY_BITS    (KEY_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (q_stat.head_valid),
    .pop_o        (pop),
    .stat_o       (b_stat),
    .out_o        (out_o)
  );

  // The back never takes a command from an empty queue.
  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_stat.pop |-> q_stat.head_valid)
    else $error("command popped from empty queue");

  // No command leaves the queue while the clearing pass runs.
  a_no_pop_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_stat.sweeping |-> !b_stat.pop)
    else $error("command popped during clearing pass");

  // The queue fill never exceeds its depth.
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= bpks_pkg::QueueCntBits'(bpks_pkg::QueueDepth))
    else $error("command queue overfilled");

endmodule

FILE: dv/bounded_probe_key_set_unit_tb.sv
// Self-checking testbench of the bounded probe key set unit, with a shadow table as predictor.
module bounded_probe_key_set_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [bpks_pkg::KeyWidth-1:0] key_t;
  typedef logic [bpks_pkg::OpBits-1:0]   op_t;

  localparam int unsigned SlotCount  = bpks_pkg::DefTableSlots;
  localparam int unsigned ProbeCount = bpks_pkg::DefProbeCount;
  localparam op_t         OpUnused   = 2'd3;
  // Up to three clears can be in flight (one in the back, two queued), each sweeping
  // every slot, so allow three full sweeps plus slack before touching the register.
  localparam int unsigned SettleCycles = 3 * (SlotCount + 2) + 64;
  localparam int unsigned ResetCycles  = 12;
  localparam int unsigned PhaseItems   = 325;
  localparam int unsigned ReportLimit  = 10;

  // Shadow copy of the key table: predicts every lookup answer and holds them in order.
  class key_set_shadow;
    key_t        slot_key [SlotCount];
    bit          slot_used [SlotCount];
    bit          any_stored;
    bit          insert_enable;
    bit          pending_hits [$];
    int unsigned errors, inserts, stored, lookups, hits, clears, unused_ops;

    function int unsigned home_slot(key_t key);
      return ((key >> 6) ^ (key >> 3)) & (SlotCount - 1);
    endfunction

    function void store_key(key_t key);
      int unsigned home, s;
      home = home_slot(key);
      for (int unsigned i = 0; i < ProbeCount; i++) begin
        s = (home + i) & (SlotCount - 1);
        if (slot_used[s] && slot_key[s] == key) return;
        if (!slot_used[s]) begin
          slot_key[s]  = key;
          slot_used[s] = 1'b1;
          any_stored   = 1'b1;
          stored++;
          return;
        end
      end
      // every probe taken by another key: evict the home slot
      slot_key[home]  = key;
      slot_used[home] = 1'b1;
      any_stored      = 1'b1;
      stored++;
    endfunction

    function bit lookup_hit(key_t key);
      int unsigned home, s;
      home = home_slot(key);
      if (!any_stored || key == '0) return 1'b0;
      for (int unsigned i = 0; i < ProbeCount; i++) begin
        s = (home + i) & (SlotCount - 1);
        if (!slot_used[s]) return 1'b0;
        if (slot_key[s] == key) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_request(op_t op, key_t key);
      case (op)
        bpks_pkg::OP_INSERT: begin
          inserts++;
          if (insert_enable && key != '0) store_key(key);
        end
        bpks_pkg::OP_LOOKUP: begin
          lookups++;
          pending_hits.push_back(lookup_hit(key));
        end
        bpks_pkg::OP_CLEAR: begin
          clears++;
          foreach (slot_used[i]) slot_used[i] = 1'b0;
          any_stored = 1'b0;
        end
        default: unused_ops++;
      endcase
    endfunction

    function void check_hit(logic hit);
      bit want;
      if (pending_hits.size() == 0) begin
        errors++;
        if (errors <= ReportLimit) begin
          $display("[%0t] unexpected result transaction, hit=%0b", $realtime, hit);
        end
        return;
      end
      want = pending_hits.pop_front();
      if (want) hits++;
      if (hit !== want) begin
        errors++;
        if (errors <= ReportLimit) begin
          $display("[%0t] hit mismatch: expected %0b, got %0b", $realtime, want, hit);
        end
      end
    endfunction
  endclass

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic cfg_we_i    = 1'b0;
  logic cfg_wdata_i = 1'b0;

  bpks_in_if  req_if ();
  bpks_out_if res_if ();

  key_set_shadow shadow = new();

  // Cluster bases for the random keys: keys sharing the low 16 bits share a home slot.
  logic [15:0] cluster_base [4];

  // Receiver stall pattern: a rotating 16-bit mask, reloaded when its age counter runs out.
  logic [15:0] ready_pattern = '1;
  int unsigned pattern_age   = 0;

  bounded_probe_key_set_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (req_if),
    .out_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Drive the result-side ready from the stall pattern; some reloads never stall.
  always @(posedge clk_i) begin
    if (pattern_age == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pattern <= '1;
        1: ready_pattern <= 16'($urandom) | 16'h0001;
        2: ready_pattern <= 16'h00FF;
        default: ready_pattern <= 16'hAAAA;
      endcase
      pattern_age <= 47;
    end else begin
      ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      pattern_age   <= pattern_age - 1;
    end
    res_if.ready <= ready_pattern[0];
  end

  // Sample both channels at the edge: note every accepted request, check every result.
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) shadow.note_request(req_if.op, req_if.key);
    if (rst_ni && res_if.valid && res_if.ready) shadow.check_hit(res_if.hit);
  end

  // Offer one request and hold it until the block takes the transaction.
  task automatic send_request(input op_t op, input key_t key);
    req_if.valid <= 1'b1;
    req_if.op    <= op;
    req_if.key   <= key;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Drop valid, drain all lookups, then let any clear sweep or trailing insert finish.
  task automatic quiesce();
    req_if.valid <= 1'b0;
    while (shadow.pending_hits.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write the register on an idle block; the shadow follows at the same edge.
  task automatic set_insert_enable(input bit value);
    quiesce();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow.insert_enable = value;
  endtask

  // Find a low key part whose home slot lies at or above min_home, so probes wrap.
  function automatic logic [15:0] near_top_base(input int unsigned min_home);
    logic [15:0] cand;
    do cand = 16'($urandom) & 16'hFFF8; while (shadow.home_slot({16'h0, cand}) < min_home);
    return cand;
  endfunction

  // Mostly clustered keys with a small upper range, so repeats, hits and evictions are common.
  function automatic key_t make_key();
    int unsigned pick;
    logic [15:0] lower;
    pick = $urandom_range(0, 99);
    if (pick < 3) return '0;
    if (pick < 15) return $urandom;
    lower = cluster_base[$urandom_range(0, 3)] + 16'(8 * $urandom_range(0, 3))
          + 16'($urandom_range(0, 1));
    return {16'($urandom_range(1, 12)), lower};
  endfunction

  task automatic run_directed();
    logic [15:0] top_base;
    localparam logic [15:0] CollideBase = 16'h4A50;
    top_base = near_top_base(SlotCount - 1);

    // set still empty and inserts disabled out of reset
    send_request(bpks_pkg::OP_LOOKUP, 32'h8000_0001);
    send_request(bpks_pkg::OP_INSERT, 32'h8000_0001);
    send_request(bpks_pkg::OP_LOOKUP, 32'h8000_0001);
    send_request(OpUnused,            32'h8000_0001);
    send_request(bpks_pkg::OP_LOOKUP, 32'h0000_0000);
    set_insert_enable(1'b1);

    // zero key is never stored; all-ones key is
    send_request(bpks_pkg::OP_INSERT, 32'h0000_0000);
    send_request(bpks_pkg::OP_LOOKUP, 32'h0000_0000);
    send_request(bpks_pkg::OP_INSERT, 32'hFFFF_FFFF);
    send_request(bpks_pkg::OP_LOOKUP, 32'hFFFF_FFFF);

    // five keys on one home slot: the fifth evicts the first, a repeat insert stops early
    for (int unsigned i = 1; i <= 5; i++) begin
      send_request(bpks_pkg::OP_INSERT, {16'(i), CollideBase});
    end
    send_request(bpks_pkg::OP_INSERT, {16'd2, CollideBase});
    send_request(bpks_pkg::OP_LOOKUP, {16'd1, CollideBase});
    send_request(bpks_pkg::OP_LOOKUP, {16'd5, CollideBase});
    send_request(bpks_pkg::OP_LOOKUP, {16'd4, CollideBase});

    // home at the last slot: probes wrap to the bottom of the table
    for (int unsigned i = 1; i <= 4; i++) begin
      send_request(bpks_pkg::OP_INSERT, {16'(i), top_base});
    end
    send_request(bpks_pkg::OP_LOOKUP, {16'd3, top_base});

    // clear empties everything
    send_request(bpks_pkg::OP_CLEAR,  32'h0000_0000);
    send_request(bpks_pkg::OP_LOOKUP, {16'd5, CollideBase});
  endtask

  // Random traffic in bursts of random length separated by random gaps.
  task automatic run_random_phase(input int unsigned count);
    int unsigned burst_left, gap, pick;
    op_t         op;
    burst_left = 0;
    cluster_base[0] = near_top_base(SlotCount - 3);
    for (int i = 1; i < 4; i++) cluster_base[i] = 16'($urandom) & 16'hFFF8;

    for (int unsigned n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          req_if.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(32, 64)
                                                  : $urandom_range(1, 16);
      end
      burst_left--;
      pick = $urandom_range(0, 199);
      if (pick < 92)       op = bpks_pkg::OP_INSERT;
      else if (pick < 194) op = bpks_pkg::OP_LOOKUP;
      else if (pick < 198) op = OpUnused;
      else                 op = bpks_pkg::OP_CLEAR;
      send_request(op, make_key());
    end
  endtask

  initial begin
    bit phase_enable [6];

    phase_enable = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    req_if.valid = 1'b0;
    req_if.op    = bpks_pkg::OP_INSERT;
    req_if.key   = '0;
    res_if.ready = 1'b0;

    // hold reset, then release on an edge
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // write the register explicitly at its reset value before anything runs
    set_insert_enable(1'b0);
    run_directed();

    foreach (phase_enable[p]) begin
      set_insert_enable(phase_enable[p]);
      run_random_phase(PhaseItems);
    end

    req_if.valid <= 1'b0;
    while (shadow.pending_hits.size() != 0) @(posedge clk_i);
    // watch for stray results after the last expected one
    repeat (SettleCycles) @(posedge clk_i);

    $display("Run covered %0d inserts (%0d stored), %0d lookups (%0d hits), %0d clears,",
             shadow.inserts, shadow.stored, shadow.lookups, shadow.hits, shadow.clears);
    $display("%0d unused-op requests and %0d failed checks.", shadow.unused_ops, shadow.errors);
    if (shadow.errors == 0 && shadow.pending_hits.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Timeout with %0d lookup results outstanding", shadow.pending_hits.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: files.f
sv/bpks_pkg.sv
sv/bpks_in_if.sv
sv/bpks_out_if.sv
sv/bpks_front.sv
sv/bpks_back.sv
sv/bounded_probe_key_set_unit.sv
dv/bounded_probe_key_set_unit_tb.sv
